[rtl/core/utf8sd_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types and fixed constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

   // byte classification masks and tags
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;

   // payload masks
   localparam logic [7:0] LEAD2_BITS = 8'h1F;
   localparam logic [7:0] LEAD3_BITS = 8'h0F;
   localparam logic [7:0] LEAD4_BITS = 8'h07;
   localparam logic [7:0] CONT_BITS  = 8'h3F;

   // smallest legal value per sequence width
   localparam logic [16:0] MIN_WIDTH2 = 17'h00080;
   localparam logic [16:0] MIN_WIDTH3 = 17'h00800;
   localparam logic [16:0] MIN_WIDTH4 = 17'h10000;

   // scalar value limits
   localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
   localparam logic [20:0] SURR_LOW   = 21'h00D800;
   localparam logic [20:0] SURR_HIGH  = 21'h00DFFF;

   // reset value of the error code point register
   localparam logic [20:0] ERR_CP_RESET = 21'h00FFFD;

   // results caused by one byte: a run of errors, then an optional tail result
   typedef struct packed {
      logic [2:0]  err_count;
      logic        tail_valid;
      logic [20:0] tail_code;
      logic        tail_error;
      logic        last_byte;
   } burst_type;

endpackage

[rtl/core/utf8sd_decode.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder - byte decode stage
// Input register, pending sequence state and the per-byte decode that turns
// one byte into a burst descriptor (error run plus optional tail result).
// ----------------------------------------------------------------------------
module utf8sd_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_end_of_stream,
   output logic                  burst_valid,
   input  logic                  burst_ready,
   output utf8sd_pkg::burst_type burst
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_eos_ff;
   logic        advance;

   logic [2:0]  width_ff,   width_in;
   logic [1:0]  taken_ff,   taken_in;
   logic [20:0] partial_ff, partial_in;
   logic [16:0] minval_ff,  minval_in;

   logic        is_cont;
   logic        f_res, f_err, f_start;
   logic [20:0] f_code;
   logic [2:0]  f_width;
   logic [20:0] f_payload;
   logic [16:0] f_min;

   logic [1:0]  step_taken;
   logic [20:0] step_code;
   logic        complete;
   logic        bad_value;
   logic        use_fresh;
   utf8sd_pkg::burst_type desc;

   // input register: holds one byte until the burst stage can take it
   assign advance     = in_valid_ff && burst_ready;
   assign req_ready   = !in_valid_ff || advance;
   assign burst_valid = in_valid_ff;
   assign burst       = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   // decode of a byte with no sequence pending
   always_comb begin
      f_res     = 1'b0;
      f_err     = 1'b0;
      f_start   = 1'b0;
      f_code    = 21'(in_byte_ff);
      f_width   = 3'd0;
      f_payload = 21'd0;
      f_min     = 17'd0;
      if (!in_byte_ff[7]) begin
         f_res = 1'b1;
      end else if ((in_byte_ff & utf8sd_pkg::CONT_MASK) == utf8sd_pkg::CONT_TAG) begin
         f_res = 1'b1;
         f_err = 1'b1;
      end else if ((in_byte_ff & utf8sd_pkg::LEAD2_MASK) == utf8sd_pkg::LEAD2_TAG) begin
         f_start   = 1'b1;
         f_width   = 3'd2;
         f_payload = 21'(in_byte_ff & utf8sd_pkg::LEAD2_BITS);
         f_min     = utf8sd_pkg::MIN_WIDTH2;
      end else if ((in_byte_ff & utf8sd_pkg::LEAD3_MASK) == utf8sd_pkg::LEAD3_TAG) begin
         f_start   = 1'b1;
         f_width   = 3'd3;
         f_payload = 21'(in_byte_ff & utf8sd_pkg::LEAD3_BITS);
         f_min     = utf8sd_pkg::MIN_WIDTH3;
      end else if ((in_byte_ff & utf8sd_pkg::LEAD4_MASK) == utf8sd_pkg::LEAD4_TAG) begin
         f_start   = 1'b1;
         f_width   = 3'd4;
         f_payload = 21'(in_byte_ff & utf8sd_pkg::LEAD4_BITS);
         f_min     = utf8sd_pkg::MIN_WIDTH4;
      end else begin
         f_res = 1'b1;
         f_err = 1'b1;
      end
      // a lead byte that ends the string is one error
      if (f_start && in_eos_ff) begin
         f_start = 1'b0;
         f_res   = 1'b1;
         f_err   = 1'b1;
      end
   end

   // continuation step of a pending sequence
   assign is_cont    = (in_byte_ff & utf8sd_pkg::CONT_MASK) == utf8sd_pkg::CONT_TAG;
   assign step_taken = taken_ff + 2'd1;
   assign step_code  = {partial_ff[14:0], 6'(in_byte_ff & utf8sd_pkg::CONT_BITS)};
   assign complete   = ({1'b0, step_taken} + 3'd1) >= width_ff;
   assign bad_value  = (step_code < {4'd0, minval_ff}) || (step_code > utf8sd_pkg::MAX_SCALAR)
                       || ((step_code >= utf8sd_pkg::SURR_LOW)
                           && (step_code <= utf8sd_pkg::SURR_HIGH));

   // burst descriptor and next pending state
   always_comb begin
      desc.err_count  = 3'd0;
      desc.tail_valid = 1'b0;
      desc.tail_code  = f_code;
      desc.tail_error = f_err;
      desc.last_byte  = in_eos_ff;
      width_in        = width_ff;
      taken_in        = taken_ff;
      partial_in      = partial_ff;
      minval_in       = minval_ff;
      use_fresh       = 1'b1;

      if (width_ff != 3'd0) begin
         if (is_cont) begin
            use_fresh = 1'b0;
            if (complete) begin
               if (bad_value) begin
                  desc.err_count = width_ff;
               end else begin
                  desc.tail_valid = 1'b1;
                  desc.tail_code  = step_code;
                  desc.tail_error = 1'b0;
               end
               width_in   = 3'd0;
               taken_in   = 2'd0;
               partial_in = 21'd0;
               minval_in  = 17'd0;
            end else if (in_eos_ff) begin
               // truncated: lead byte plus every continuation held
               desc.err_count = {1'b0, step_taken} + 3'd1;
            end else begin
               taken_in   = step_taken;
               partial_in = step_code;
            end
         end else begin
            // broken sequence: flush it, then decode this byte afresh
            desc.err_count = {1'b0, taken_ff} + 3'd1;
            width_in   = 3'd0;
            taken_in   = 2'd0;
            partial_in = 21'd0;
            minval_in  = 17'd0;
         end
      end

      if (use_fresh) begin
         desc.tail_valid = f_res;
         desc.tail_code  = f_code;
         desc.tail_error = f_err;
         if (f_start) begin
            width_in   = f_width;
            taken_in   = 2'd0;
            partial_in = f_payload;
            minval_in  = f_min;
         end
      end

      // end of string drops any pending sequence
      if (in_eos_ff) begin
         width_in   = 3'd0;
         taken_in   = 2'd0;
         partial_in = 21'd0;
         minval_in  = 17'd0;
      end
   end

   // pending sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 3'd0;
         taken_ff   <= 2'd0;
         partial_ff <= 21'd0;
         minval_ff  <= 17'd0;
      end else if (advance) begin
         width_ff   <= width_in;
         taken_ff   <= taken_in;
         partial_ff <= partial_in;
         minval_ff  <= minval_in;
      end
   end

endmodule

[rtl/core/utf8sd_emit.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder - result emitter
// Burst register that issues one result per cycle while the output register
// is free, the rune counter and validity flag, and the result output register.
// ----------------------------------------------------------------------------
module utf8sd_emit #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  burst_valid,
   output logic                  burst_ready,
   input  utf8sd_pkg::burst_type burst,
   input  logic [20:0]           err_code_point,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [20:0]           rsp_code_point,
   output logic                  rsp_is_error,
   output logic                  rsp_run_last,
   output logic [31:0]           rsp_rune_total,
   output logic                  rsp_stream_valid,
   output logic                  rsp_stream_done
);

   localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

   logic [2:0]  left_ff, left_in;
   logic        tail_v_ff, tail_v_in;
   logic [20:0] tail_code_ff;
   logic        tail_err_ff;
   logic        eos_ff;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   ok_ff, ok_in;
   logic [COUNT_WIDTH-1:0] count_next;

   logic        rsp_valid_ff;
   logic [20:0] rsp_code_ff;
   logic        rsp_err_ff;
   logic        rsp_last_ff;
   logic [31:0] rsp_total_ff;
   logic        rsp_ok_ff;
   logic        rsp_done_ff;

   logic        busy, rsp_free, issue, issue_last, issue_err, load;
   logic [20:0] issue_code;

   // issue control
   assign busy        = (left_ff != 3'd0) || tail_v_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign issue       = busy && rsp_free;
   assign issue_last  = ((left_ff == 3'd1) && !tail_v_ff) || ((left_ff == 3'd0) && tail_v_ff);
   assign issue_err   = (left_ff != 3'd0) || tail_err_ff;
   assign issue_code  = issue_err ? err_code_point : tail_code_ff;
   assign burst_ready = !busy || (issue && issue_last);
   assign load        = burst_valid && burst_ready;

   // burst bookkeeping
   always_comb begin
      left_in   = left_ff;
      tail_v_in = tail_v_ff;
      if (issue) begin
         if (left_ff != 3'd0) begin
            left_in = left_ff - 3'd1;
         end else begin
            tail_v_in = 1'b0;
         end
      end
      if (load) begin
         left_in   = burst.err_count;
         tail_v_in = burst.tail_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= 3'd0;
         tail_v_ff <= 1'b0;
      end else begin
         left_ff   <= left_in;
         tail_v_ff <= tail_v_in;
      end
      if (load) begin
         tail_code_ff <= burst.tail_code;
         tail_err_ff  <= burst.tail_error;
         eos_ff       <= burst.last_byte;
      end
   end

   // saturating rune count and validity, restarted after the final byte
   assign count_next = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      ok_in    = ok_ff;
      if (issue) begin
         if (issue_last && eos_ff) begin
            count_in = '0;
            ok_in    = 1'b1;
         end else begin
            count_in = count_next;
            ok_in    = ok_ff && !issue_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ok_ff    <= 1'b1;
      end else begin
         count_ff <= count_in;
         ok_ff    <= ok_in;
      end
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (issue) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (issue) begin
         rsp_code_ff  <= issue_code;
         rsp_err_ff   <= issue_err;
         rsp_last_ff  <= issue_last;
         rsp_total_ff <= 32'(count_next);
         rsp_ok_ff    <= ok_ff && !issue_err;
         rsp_done_ff  <= issue_last && eos_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_point   = rsp_code_ff;
   assign rsp_is_error     = rsp_err_ff;
   assign rsp_run_last     = rsp_last_ff;
   assign rsp_rune_total   = rsp_total_ff;
   assign rsp_stream_valid = rsp_ok_ff;
   assign rsp_stream_done  = rsp_done_ff;

   // checks
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_run_last)
      else $error("stream_done without run_last");

   a_error_clears_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_error |-> !rsp_stream_valid)
      else $error("error result reported with stream still valid");

   a_restart_after_eos: assert property (@(posedge clock) disable iff (reset)
      issue && issue_last && eos_ff |=> (count_ff == '0) && ok_ff)
      else $error("rune count not restarted after final byte");

   a_idle_takes_burst: assert property (@(posedge clock) disable iff (reset)
      !busy |-> burst_ready)
      else $error("empty burst stage refused a descriptor");

endmodule

[rtl/core/utf8_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder unit
// Decodes a UTF-8 byte stream into code points with error reporting, a
// saturating rune count and a per-string validity flag.
// ----------------------------------------------------------------------------
// A byte is taken every cycle as long as each byte causes at most one result
// and the output is not stalled. A byte that causes k results (an error flush
// of up to four) issues them one result per cycle while the output is not
// stalled, and the input side waits while that run drains. The byte enters
// the input register at its transfer edge. Its first result then passes
// through the burst register into the output register. The error code point
// register may be written only while no transfer is in flight.
module utf8_stream_decoder_unit #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic        rsp_is_error,
   output logic        rsp_run_last,
   output logic [31:0] rsp_rune_total,
   output logic        rsp_stream_valid,
   output logic        rsp_stream_done,
   input  logic        csr_wr_en,
   input  logic [20:0] csr_wr_data
);

   logic [20:0]           err_cp_ff;
   logic                  burst_valid;
   logic                  burst_ready;
   utf8sd_pkg::burst_type burst;

   // error code point register
   always_ff @(posedge clock) begin
      if (reset) begin
         err_cp_ff <= utf8sd_pkg::ERR_CP_RESET;
      end else if (csr_wr_en) begin
         err_cp_ff <= csr_wr_data;
      end
   end

   utf8sd_decode u_decode (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .burst_valid       (burst_valid),
      .burst_ready       (burst_ready),
      .burst             (burst)
   );

   utf8sd_emit #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .burst_valid      (burst_valid),
      .burst_ready      (burst_ready),
      .burst            (burst),
      .err_code_point   (err_cp_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_is_error     (rsp_is_error),
      .rsp_run_last     (rsp_run_last),
      .rsp_rune_total   (rsp_rune_total),
      .rsp_stream_valid (rsp_stream_valid),
      .rsp_stream_done  (rsp_stream_done)
   );

endmodule
